@@ hw/rtl/lis_pkg.sv @@
// ----------------------------------------------------------------------------
// lis_pkg
// Shared item types for the longest increasing subsequence unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  // input item: one sequence element
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  // result item: one per input element
  typedef struct packed {
    logic [9:0]  index;
    logic [10:0] length;
    logic        has_predecessor;
    logic [9:0]  predecessor;
    logic [10:0] best;
    logic        overflow;
    logic        final_res;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/lis_fifo.sv @@
// ----------------------------------------------------------------------------
// lis_fifo
// Two-entry register queue, generic over the item type.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_fifo #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  T           entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rp];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lis_front.sv @@
// ----------------------------------------------------------------------------
// lis_front
// Accepts items, numbers them within the sequence and flags store overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_front
  import lis_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire in_t                          data,
  output logic                              full,
  input  wire logic                         q_full,
  output logic                              q_push,
  output logic signed [VALUE_BITS-1:0]      key,
  output logic [AW:0]                       idx,
  output logic                              ovf,
  output logic                              last
);

  logic [AW:0] cnt;

  // classify the arriving item
  assign full   = q_full;
  assign q_push = push && !q_full;
  assign key    = VALUE_BITS'($signed(data.value));
  assign ovf    = (cnt == (AW+1)'(DEPTH));
  assign idx    = cnt;
  assign last   = data.last;

  // position within the current sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      if (data.last) begin
        cnt <= '0;
      end else if (!ovf) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lis_back.sv @@
// ----------------------------------------------------------------------------
// lis_back
// Scans stored elements one per cycle and builds each result item.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_back
  import lis_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          t_empty,
  input  wire logic signed [VALUE_BITS-1:0]  t_key,
  input  wire logic [AW:0]                   t_idx,
  input  wire logic                          t_ovf,
  input  wire logic                          t_last,
  output logic                               t_pop,
  input  wire logic                          r_full,
  output logic                               r_push,
  output res_t                               r_data
);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                        state;
  logic signed [VALUE_BITS-1:0]  key;
  logic [AW:0]                   n;
  logic                          ovf;
  logic                          last;
  logic [AW:0]                   ra;
  logic                          rv;
  logic [AW-1:0]                 ridx;
  logic [AW:0]                   top;
  logic [AW-1:0]                 from;
  logic                          found;
  logic [AW:0]                   best;

  // element and length memory
  logic signed [VALUE_BITS-1:0]  elem_mem [DEPTH];
  logic [AW:0]                   len_mem  [DEPTH];
  logic signed [VALUE_BITS-1:0]  rd_elem;
  logic [AW:0]                   rd_len;

  logic                          issue;
  logic                          hit;
  logic                          we;
  logic [AW:0]                   len_new;
  logic [AW:0]                   best_upd;

  assign t_pop    = (state == IDLE) && !t_empty;
  assign issue    = (state == SCAN) && (ra < n);
  assign hit      = rv && (rd_elem < key) && (rd_len > top);
  assign we       = (state == SCAN) && (ra == n) && !rv;
  assign len_new  = top + 1'b1;
  assign best_upd = (!ovf && (len_new > best)) ? len_new : best;
  assign r_push   = (state == DONE) && !r_full;

  // result fields
  always_comb begin
    r_data.index           = ovf ? 10'd0 : 10'(n);
    r_data.length          = ovf ? 11'd0 : 11'(len_new);
    r_data.has_predecessor = found;
    r_data.predecessor     = found ? 10'(from) : 10'd0;
    r_data.best            = 11'(best_upd);
    r_data.overflow        = ovf;
    r_data.final_res       = last;
  end

  // one read and one write port, registered read
  always_ff @(posedge clk) begin
    rd_elem <= elem_mem[ra[AW-1:0]];
    rd_len  <= len_mem[ra[AW-1:0]];
    if (we) begin
      elem_mem[n[AW-1:0]] <= key;
      len_mem[n[AW-1:0]]  <= len_new;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rv    <= 1'b0;
      best  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          rv <= 1'b0;
          if (!t_empty) begin
            key   <= t_key;
            n     <= t_idx;
            ovf   <= t_ovf;
            last  <= t_last;
            ra    <= '0;
            top   <= '0;
            from  <= '0;
            found <= 1'b0;
            state <= t_ovf ? DONE : SCAN;
          end
        end
        SCAN: begin
          rv <= issue;
          if (issue) begin
            ridx <= ra[AW-1:0];
            ra   <= ra + 1'b1;
          end
          if (hit) begin
            top   <= rd_len;
            from  <= ridx;
            found <= 1'b1;
          end
          if (we) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!r_full) begin
            best  <= last ? '0 : best_upd;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/longest_increasing_subsequence_unit.sv @@
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_unit
// Running longest increasing subsequence over a stream of signed elements.
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive data and raise push; an item is taken when push is
//   high and full is low. data.last closes the sequence; the next item
//   starts a new one.
//   result queue: while empty is low the oldest result sits on result;
//   raise pop to take it. one result per input item, in order.
// scan engine:
//   an element at position k of its sequence is loaded, then the k
//   stored elements before it are read, one per cycle, from the element
//   memory (one read and one write port); the last read drains, the
//   element is written and its result is offered. an overflowed element
//   skips the scan and goes straight to its result.
//   a two-entry queue sits before the scan engine and after it, so items
//   are taken while results wait.
// reset:
//   rst clears the sequence position, running best and both queues; the
//   memories need no clearing. if pop stays low the result queue fills,
//   the engine holds its finished item, and full rises once the input
//   queue is full too.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_increasing_subsequence_unit
  import lis_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire in_t  data,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output res_t      result
);

  localparam int AW = $clog2(DEPTH);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] key;
    logic [AW:0]                  idx;
    logic                         ovf;
    logic                         last;
  } task_t;

  task_t task_in;
  task_t task_out;
  logic  q_full;
  logic  q_push;
  logic  q_empty;
  logic  q_pop;
  logic  r_full;
  logic  r_push;
  res_t  r_data;

  // front: accept and classify
  lis_front #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .data   (data),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .key    (task_in.key),
    .idx    (task_in.idx),
    .ovf    (task_in.ovf),
    .last   (task_in.last)
  );

  // queue between front and scan engine
  lis_fifo #(
    .T (task_t)
  ) u_task_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (task_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (task_out),
    .empty (q_empty)
  );

  // scan engine
  lis_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .t_empty (q_empty),
    .t_key   (task_out.key),
    .t_idx   (task_out.idx),
    .t_ovf   (task_out.ovf),
    .t_last  (task_out.last),
    .t_pop   (q_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_data)
  );

  // result queue
  lis_fifo #(
    .T (res_t)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_data),
    .full  (r_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  // engine never pushes a result into a full queue
  a_res_push: assert property (@(posedge clk) disable iff (rst) r_push |-> !r_full)
    else $error("result pushed into full queue");

  // engine never pops an empty task queue
  a_task_pop: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("task popped from empty queue");

  // a dropped element carries no position and no predecessor
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
      (!empty && result.overflow) |-> (!result.has_predecessor && result.index == 10'd0))
    else $error("overflow result has nonzero fields");
`endif

endmodule

`default_nettype wire
